[hw/rtl/kecache_pkg.sv]
// ----------------------------------------------------------------------------
// kecache_pkg
// Shared types and constants for the keyed entry cache.
// ----------------------------------------------------------------------------
package kecache_pkg;

	localparam int CACHE_ENTRIES = 8;
	localparam int HANDLE_BITS   = 16;
	localparam int IDX_BITS      = $clog2(CACHE_ENTRIES);
	localparam int CNT_BITS      = $clog2(CACHE_ENTRIES + 1);
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] ST_HIT    = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_STORED = 2'd2;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic                   command;
		logic [63:0]            peer_tag;
		logic [63:0]            key_tag;
		logic [31:0]            time_stamp;
		logic [15:0]            message_size;
		logic [HANDLE_BITS-1:0] message_handle;
	} req_t;

endpackage

[hw/rtl/kecache_front.sv]
// ----------------------------------------------------------------------------
// kecache_front
// Accepts request items and buffers them in a short queue for the back end.
// ----------------------------------------------------------------------------
module kecache_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  kecache_pkg::req_t           in_req,
	output logic                        q_valid,
	input  logic                        q_ready,
	output kecache_pkg::req_t           q_req
);
	import kecache_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	req_t                 mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [PTR_BITS:0]    count_q;
	logic                 push;
	logic                 pop;

	assign in_ready = (count_q != (PTR_BITS+1)'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_req    = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			if (push && !pop)      count_q <= count_q + (PTR_BITS+1)'(1);
			else if (pop && !push) count_q <= count_q - (PTR_BITS+1)'(1);
		end
	end

endmodule

[hw/rtl/kecache_back.sv]
// ----------------------------------------------------------------------------
// kecache_back
// Scans the entries one per cycle and applies a get or put; holds the result.
// ----------------------------------------------------------------------------
module kecache_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	output logic                                   q_ready,
	input  kecache_pkg::req_t                      q_req,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             status,
	output logic [kecache_pkg::HANDLE_BITS-1:0]    hit_handle,
	output logic                                   released_valid,
	output logic [kecache_pkg::HANDLE_BITS-1:0]    released_handle
);
	import kecache_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_APPLY = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t                  state_q;
	req_t                    req_q;
	logic [IDX_BITS-1:0]     idx_q;

	logic                    valid_q  [CACHE_ENTRIES];
	logic [63:0]             peer_q   [CACHE_ENTRIES];
	logic [63:0]             key_q    [CACHE_ENTRIES];
	logic [31:0]             time_q   [CACHE_ENTRIES];
	logic [15:0]             size_q   [CACHE_ENTRIES];
	logic [HANDLE_BITS-1:0]  handle_q [CACHE_ENTRIES];
	logic [IDX_BITS-1:0]     rank_q   [CACHE_ENTRIES];

	// scan results
	logic                    hit_q;
	logic [IDX_BITS-1:0]     hit_idx_q;
	logic                    free_q;
	logic [IDX_BITS-1:0]     free_idx_q;
	logic                    vic_q;
	logic [IDX_BITS-1:0]     vic_idx_q;

	logic                    match;
	logic                    better;

	always_comb begin
		match = valid_q[idx_q] && (peer_q[idx_q] == req_q.peer_tag);
		if (req_q.command == CMD_GET) begin
			match = match && (key_q[idx_q] == req_q.key_tag) &&
				(time_q[idx_q] == req_q.time_stamp) &&
				(size_q[idx_q] == req_q.message_size);
		end
		better = !vic_q || (time_q[idx_q] < time_q[vic_idx_q]) ||
			((time_q[idx_q] == time_q[vic_idx_q]) && (rank_q[idx_q] < rank_q[vic_idx_q]));
	end

	assign q_ready   = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			req_q <= q_req;
		end
		if (state_q == S_APPLY && req_q.command == CMD_PUT) begin
			if (hit_q) begin
				key_q[hit_idx_q]    <= req_q.key_tag;
				time_q[hit_idx_q]   <= req_q.time_stamp;
				size_q[hit_idx_q]   <= req_q.message_size;
				handle_q[hit_idx_q] <= req_q.message_handle;
			end else if (free_q || req_q.time_stamp > time_q[vic_idx_q]) begin
				for (int i = 0; i < CACHE_ENTRIES; i++) begin
					if (valid_q[i] && (free_q || rank_q[i] < rank_q[vic_idx_q])) begin
						rank_q[i] <= rank_q[i] + IDX_BITS'(1);
					end
				end
				rank_q[free_q ? free_idx_q : vic_idx_q]   <= '0;
				peer_q[free_q ? free_idx_q : vic_idx_q]   <= req_q.peer_tag;
				key_q[free_q ? free_idx_q : vic_idx_q]    <= req_q.key_tag;
				time_q[free_q ? free_idx_q : vic_idx_q]   <= req_q.time_stamp;
				size_q[free_q ? free_idx_q : vic_idx_q]   <= req_q.message_size;
				handle_q[free_q ? free_idx_q : vic_idx_q] <= req_q.message_handle;
			end
		end
		if (state_q == S_APPLY) begin
			if (req_q.command == CMD_GET) begin
				status          <= hit_q ? ST_HIT : ST_MISS;
				hit_handle      <= hit_q ? handle_q[hit_idx_q] : '0;
				released_valid  <= 1'b0;
				released_handle <= '0;
			end else begin
				status         <= ST_STORED;
				hit_handle     <= '0;
				released_valid <= hit_q || !free_q;
				if (hit_q) begin
					released_handle <= handle_q[hit_idx_q];
				end else if (!free_q) begin
					released_handle <= (req_q.time_stamp <= time_q[vic_idx_q]) ?
						req_q.message_handle : handle_q[vic_idx_q];
				end else begin
					released_handle <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			vic_q   <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			vic_idx_q  <= '0;
			for (int i = 0; i < CACHE_ENTRIES; i++) valid_q[i] <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						vic_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					if (match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!valid_q[idx_q] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (valid_q[idx_q] && better) begin
						vic_q     <= 1'b1;
						vic_idx_q <= idx_q;
					end
					if (idx_q == IDX_BITS'(CACHE_ENTRIES - 1)) state_q <= S_APPLY;
					else idx_q <= idx_q + IDX_BITS'(1);
				end
				S_APPLY: begin
					if (req_q.command == CMD_PUT && !hit_q && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/keyed_entry_cache_min_time_evict.sv]
// ----------------------------------------------------------------------------
// keyed_entry_cache_min_time_evict
// Eight-entry peer-keyed cache with minimum-time eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready) carries one item: a get (command 0)
//   or a put (command 1) with peer, key, time, size and handle fields.
//   Result channel (out_valid/out_ready) returns exactly one item per request:
//   status, hit handle, and the handle released by a put, if any.
//   The front end queues up to two requests so the sender can keep going
//   while the back end works. The back end scans one entry per cycle:
//   out_valid rises once an accepted item has passed the scan of all
//   CACHE_ENTRIES entries and the apply step, and the back end takes the
//   next request only after the receiver has taken the result.
//   That scan through the entry registers bounds how fast requests complete.
//   Reset (arst_n low) empties the cache and the request queue.
//   A stalled receiver holds the result; the back end waits and the queue
//   fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module keyed_entry_cache_min_time_evict (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [63:0]                         peer_tag,
	input  logic [63:0]                         key_tag,
	input  logic [31:0]                         time_stamp,
	input  logic [15:0]                         message_size,
	input  logic [kecache_pkg::HANDLE_BITS-1:0] message_handle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [kecache_pkg::HANDLE_BITS-1:0] hit_handle,
	output logic                                released_valid,
	output logic [kecache_pkg::HANDLE_BITS-1:0] released_handle
);
	import kecache_pkg::*;

	req_t in_req;
	req_t q_req;
	logic q_valid;
	logic q_ready;

	assign in_req = '{command: command, peer_tag: peer_tag, key_tag: key_tag,
		time_stamp: time_stamp, message_size: message_size,
		message_handle: message_handle};

	// front: accept and buffer requests
	kecache_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req)
	);

	// back: scan entries, update the cache, hold the result
	kecache_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.q_req           (q_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.hit_handle      (hit_handle),
		.released_valid  (released_valid),
		.released_handle (released_handle)
	);

endmodule
